// File: rtl/pcc_pkg.sv
package pcc_pkg;

    // Palette geometry
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int COLOR_W         = 24;

    // Width for index sums (start + offset reaches 510, start + count - 1 reaches 765)
    localparam int SUM_W = 10;
    localparam int CMP_W = (SUM_W > IDX_W + 1) ? SUM_W : IDX_W + 1;

    // Stage time width and remainder unit step count
    localparam int TIME_W    = 32;
    localparam int REM_CNT_W = $clog2(TIME_W);

    // Operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_ROTATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic [7:0]          start_index;
        logic [7:0]          offset;
        logic [8:0]          count;
        logic signed [7:0]   speed;
        logic [TIME_W-1:0]   stage_time;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic       rotated;
        logic       dropped;
    } t_out_item;

    // Status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

// File: rtl/pcc_in_if.sv
interface pcc_in_if import pcc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pcc_out_if.sv
interface pcc_out_if import pcc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pcc_ram.sv
module pcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pcc_rem.sv
module pcc_rem import pcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_dividend,
    input  logic [7:0]        i_divisor,
    output t_rem_status       o_status
);

    logic                 r_busy;
    logic                 r_done;
    logic [REM_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]    r_dvd;
    logic [7:0]           r_rem;
    logic [7:0]           r_div;
    logic [8:0]           trial;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {r_rem, r_dvd[TIME_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? 8'(trial - {1'b0, r_div}) : trial[7:0];
                r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
                r_cnt <= r_cnt + REM_CNT_W'(1);
                // Finish after the last dividend bit
                if (r_cnt == REM_CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == 8'd0);

endmodule

// File: rtl/palette_color_cycler_unit.sv
// Each item runs from S_IDLE to S_RESP: an unused op code answers at once, a write or a
// read checks its index first and a read then fetches the entry from the RAM, a rotate
// that passes its checks (count clipped at the table end) runs a 32-step remainder unit
// and, if its timing test passes, a sweep of one palette entry per cycle through the RAM.
// One item at a time: the next is taken only after the previous result is registered.
// Reset (synchronous, active low) first runs a clearing pass that zeroes every entry.
module palette_color_cycler_unit import pcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcc_in_if.sink      i_in,
    pcc_out_if.source   o_out
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_RD_DATA,
        S_ROT_CHECK,
        S_MOD,
        S_SWEEP_START,
        S_SWEEP,
        S_WRAP,
        S_RESP
    } t_state;

    t_state             r_state, n_state;
    t_in_item           r_item, n_item;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_clr, n_clr;
    logic [IDX_W-1:0]   r_begin, n_begin;
    logic [IDX_W-1:0]   r_stop, n_stop;
    logic               r_up, n_up;
    logic [IDX_W-1:0]   r_q, n_q;
    logic [IDX_W-1:0]   r_rd_addr, n_rd_addr;
    logic [COLOR_W-1:0] r_carry, n_carry;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [COLOR_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [COLOR_W-1:0] ram_rdata;

    logic               rem_start;
    t_rem_status        rem_status;

    logic [CMP_W-1:0]   idx_sum;
    logic               idx_ok;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         spd_u;
    logic [7:0]         mag;
    logic [CMP_W-1:0]   start_ext;
    logic [CMP_W-1:0]   last_sum;
    logic [CMP_W-1:0]   last_clip;
    logic               rot_ok;
    logic               out_free;

    pcc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pcc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_item.stage_time),
        .i_divisor  (mag),
        .o_status   (rem_status)
    );

    // Decode the held item: target index for writes and reads
    assign idx_sum = CMP_W'(r_item.start_index) + CMP_W'(r_item.offset);
    assign idx_ok  = idx_sum < CMP_W'(PALETTE_ENTRIES);
    assign idx     = idx_sum[IDX_W-1:0];

    // Rotation period magnitude; minus 128 negates to 128 in eight bits
    assign spd_u = r_item.speed;
    assign mag   = spd_u[7] ? 8'(~spd_u + 8'd1) : spd_u;

    // Rotate range, end clipped to the last entry
    assign start_ext = CMP_W'(r_item.start_index);
    assign last_sum  = start_ext + CMP_W'(r_item.count) - CMP_W'(1);
    assign last_clip = (last_sum > CMP_W'(PALETTE_ENTRIES - 1))
                     ? CMP_W'(PALETTE_ENTRIES - 1) : last_sum;
    assign rot_ok    = (mag != 8'd0) && (r_item.count != 9'd0)
                     && (start_ext < CMP_W'(PALETTE_ENTRIES));

    assign out_free = !r_out_valid || o_out.ready;

    // Sequencer next-state logic
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_clr       = r_clr;
        n_begin     = r_begin;
        n_stop      = r_stop;
        n_up        = r_up;
        n_q         = r_q;
        n_rd_addr   = r_rd_addr;
        n_carry     = r_carry;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_addr;
        rem_start   = 1'b0;

        // Drop the output transaction once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(PALETTE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item = i_in.data;
                    n_res  = '0;
                    unique case (i_in.data.op)
                        OP_WRITE:  n_state = S_WRITE;
                        OP_READ:   n_state = S_READ;
                        OP_ROTATE: n_state = S_ROT_CHECK;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_WRITE: begin
                if (idx_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = idx;
                    ram_wdata = {r_item.red, r_item.green, r_item.blue};
                end else begin
                    n_res.dropped = 1'b1;
                end
                n_state = S_RESP;
            end
            S_READ: begin
                if (idx_ok) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx;
                    n_state   = S_RD_DATA;
                end else begin
                    n_res.dropped = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_RD_DATA: begin
                n_res.read_red   = ram_rdata[23:16];
                n_res.read_green = ram_rdata[15:8];
                n_res.read_blue  = ram_rdata[7:0];
                n_state          = S_RESP;
            end
            S_ROT_CHECK: begin
                if (rot_ok) begin
                    rem_start = 1'b1;
                    n_up      = !spd_u[7];
                    // Sweep runs from the slot that takes the wrapped entry toward the other end
                    n_begin   = spd_u[7] ? last_clip[IDX_W-1:0] : start_ext[IDX_W-1:0];
                    n_stop    = spd_u[7] ? start_ext[IDX_W-1:0] : last_clip[IDX_W-1:0];
                    n_state   = S_MOD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_MOD: begin
                if (rem_status.done) begin
                    n_state = rem_status.zero ? S_SWEEP_START : S_RESP;
                end
            end
            S_SWEEP_START: begin
                ram_re    = 1'b1;
                ram_raddr = r_begin;
                n_q       = r_begin;
                n_rd_addr = r_up ? r_begin + IDX_W'(1) : r_begin - IDX_W'(1);
                n_state   = S_SWEEP;
            end
            S_SWEEP: begin
                // Shift the carried entry into this slot, pick up the old one
                if (r_q != r_begin) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_q;
                    ram_wdata = r_carry;
                end
                n_carry = ram_rdata;
                if (r_q == r_stop) begin
                    n_state = S_WRAP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_addr;
                    n_q       = r_rd_addr;
                    n_rd_addr = r_up ? r_rd_addr + IDX_W'(1) : r_rd_addr - IDX_W'(1);
                end
            end
            S_WRAP: begin
                // Close the cycle: the far end wraps into the first slot
                ram_we        = 1'b1;
                ram_waddr     = r_begin;
                ram_wdata     = r_carry;
                n_res.rotated = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_clr       <= n_clr;
        end
        r_item    <= n_item;
        r_res     <= n_res;
        r_out     <= n_out;
        r_begin   <= n_begin;
        r_stop    <= n_stop;
        r_up      <= n_up;
        r_q       <= n_q;
        r_rd_addr <= n_rd_addr;
        r_carry   <= n_carry;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
